FILE: design/sia_pkg.sv
// Shared constants for the sorted insert array: field widths, operation
// and status codes.
// No dependencies.
package sia_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int IDX_W  = 4;
  localparam int ST_W   = 2;
  localparam int ECNT_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

endpackage

FILE: design/sia_ram.sv
// Entry store of the sorted insert array: one write port, one read port,
// registered read data. Depends on sia_pkg.
module sia_ram
  import sia_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/sorted_insert_array.sv
// Sorted insert array: ascending unsigned table of up to DEPTH entries in
// one synchronous RAM, with insert, lookup-by-index and remove-by-index.
// Depends on sia_pkg and sia_ram.
//
//   channel  ports                                 handshake
//   input    in_op, in_value, in_index             start && !busy
//   result   out_read_value, out_status,           out_valid, one cycle
//            out_entry_count
//
// Each transaction gives one result. The RAM does one read and one write a
// cycle; shifts walk it one entry a cycle. Insert moves up the entries not
// less than the value and writes it in; remove moves those above index down.
// busy is high while a shift or read is under way and drops
// in the strobe cycle, so the next transaction may start there.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// The receiver cannot stall: a result is shown for exactly one cycle.
module sorted_insert_array
  import sia_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_op,
  input  logic [DATA_W-1:0] in_value,
  input  logic [IDX_W-1:0]  in_index,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_read_value,
  output logic [ST_W-1:0]   out_status,
  output logic [ECNT_W-1:0] out_entry_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_INS0 = 3'd2;
  localparam logic [2:0] S_LKP  = 3'd3;
  localparam logic [2:0] S_REM  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [DATA_W-1:0] val_r;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [ST_W-1:0]   out_st_r;

  logic              accept;
  logic              done;
  logic [ST_W-1:0]   st_res;
  logic [DATA_W-1:0] rd_res;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  logic [CMPW-1:0]   idx_c, cnt_c;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign idx_c  = CMPW'(in_index);
  assign cnt_c  = CMPW'(count_r);

  sia_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Insert walks down from the top entry, moving entries not less than the
  // new value up by one; remove walks up from index, moving entries down.
  // The read and write of one cycle never hit the same entry.
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = val_r;
    rd_en     = 1'b0;
    rd_addr   = '0;
    done      = 1'b0;
    st_res    = ST_OK;
    rd_res    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_INSERT: begin
              if (count_r == FULL_CNT) begin
                done   = 1'b1;
                st_res = ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_data   = in_value;
                count_nxt = count_r + CW'(1);
                done      = 1'b1;
              end else begin
                ptr_nxt   = AW'(count_r - CW'(1));
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            OP_LOOKUP: begin
              if (idx_c >= cnt_c) begin
                done   = 1'b1;
                st_res = ST_RANGE;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_index);
                state_nxt = S_LKP;
              end
            end
            OP_REMOVE: begin
              if (idx_c >= cnt_c) begin
                done   = 1'b1;
                st_res = ST_RANGE;
              end else if (idx_c + CMPW'(1) == cnt_c) begin
                count_nxt = count_r - CW'(1);
                done      = 1'b1;
              end else begin
                ptr_nxt   = AW'(in_index);
                rd_en     = 1'b1;
                rd_addr   = AW'(in_index) + AW'(1);
                state_nxt = S_REM;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r + AW'(1);
        if (rd_data >= val_r) begin
          wr_data = rd_data;
          if (ptr_r == '0) begin
            state_nxt = S_INS0;
          end else begin
            ptr_nxt = ptr_r - AW'(1);
            rd_en   = 1'b1;
            rd_addr = ptr_r - AW'(1);
          end
        end else begin
          count_nxt = count_r + CW'(1);
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INS0: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CW'(1);
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_LKP: begin
        rd_res    = rd_data;
        done      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_REM: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r;
        wr_data = rd_data;
        if (CW'(ptr_r) + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
          rd_en   = 1'b1;
          rd_addr = ptr_r + AW'(2);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      val_r <= in_value;
    end
    if (done) begin
      out_rd_r <= rd_res;
      out_st_r <= st_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_rd_r;
  assign out_status      = out_st_r;
  assign out_entry_count = ECNT_W'(count_r);

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_INSERT && count_r == FULL_CNT)
      |=> (out_valid && out_status == ST_FULL && $stable(count_r)))
    else $error("insert into full table not rejected");

  a_lookup_two: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_LOOKUP) |=> (out_valid || state_r == S_LKP))
    else $error("lookup sequencing broken");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for sorted_insert_array: directed and random insert,
// lookup and remove transactions checked against an in-bench table model.
// Depends on sia_pkg and the sorted_insert_array RTL.
`timescale 1ns / 1ps

module tb_top;
  import sia_pkg::*;

  localparam int TBL_DEPTH   = 16;
  localparam int RAND_ITEMS  = 700;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } sia_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [ST_W-1:0]   status;
    logic [ECNT_W-1:0] entry_count;
  } sia_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_op = OP_UNUSED;
  logic [DATA_W-1:0] in_value = '0;
  logic [IDX_W-1:0]  in_index = '0;
  logic              out_valid;
  logic [DATA_W-1:0] out_read_value;
  logic [ST_W-1:0]   out_status;
  logic [ECNT_W-1:0] out_entry_count;

  sia_cmd_t  pending_cmds[$];
  sia_resp_t expected_resps[$];

  // table model
  logic [DATA_W-1:0] tbl[TBL_DEPTH];
  int                tbl_count = 0;

  int gen_count = 0;   // entry count as seen by the stimulus generator
  int gap_left = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int fail_cnt = 0;

  sorted_insert_array #(.DEPTH(TBL_DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_value       (in_value),
    .in_index       (in_index),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_entry_count(out_entry_count)
  );

  always #4 clk = ~clk;

  // Applies one transaction to the table model and returns its response.
  function automatic sia_resp_t apply_cmd(sia_cmd_t c);
    sia_resp_t r;
    int pos;
    int k;
    r = '0;
    r.status = ST_OK;
    case (c.op)
      OP_INSERT: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          // ahead of equal entries
          while (pos < tbl_count && tbl[pos] < c.value) pos++;
          for (k = tbl_count; k > pos; k--) tbl[k] = tbl[k-1];
          tbl[pos] = c.value;
          tbl_count++;
        end
      end
      OP_LOOKUP: begin
        if (int'(c.index) < tbl_count) r.read_value = tbl[c.index];
        else r.status = ST_RANGE;
      end
      OP_REMOVE: begin
        if (int'(c.index) >= tbl_count) begin
          r.status = ST_RANGE;
        end else begin
          for (k = int'(c.index); k + 1 < tbl_count; k++) tbl[k] = tbl[k+1];
          tbl_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = tbl_count[ECNT_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom;
    if (roll < 80) return $urandom_range(0, 7);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] value,
                         logic [IDX_W-1:0] index);
    pending_cmds.push_back('{op: op, value: value, index: index});
    if (op == OP_INSERT && gen_count < TBL_DEPTH) gen_count++;
    else if (op == OP_REMOVE && int'(index) < gen_count) gen_count--;
  endtask

  task automatic build_stimulus();
    int n;
    int k;
    int fill_bias;
    int roll;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    // directed: empty table, unused code, ordering and duplicates, full table
    add_cmd(OP_LOOKUP, '0, 4'd0);
    add_cmd(OP_REMOVE, '0, 4'd0);
    add_cmd(OP_UNUSED, $urandom, 4'($urandom));
    add_cmd(OP_INSERT, '0, 4'($urandom));
    add_cmd(OP_INSERT, '1, 4'($urandom));
    add_cmd(OP_INSERT, '0, 4'($urandom));
    add_cmd(OP_INSERT, 32'h8000_0000, 4'($urandom));
    add_cmd(OP_LOOKUP, $urandom, 4'd0);
    add_cmd(OP_LOOKUP, $urandom, 4'd3);
    add_cmd(OP_LOOKUP, $urandom, 4'd4);
    for (k = 0; k < 12; k++) add_cmd(OP_INSERT, pick_value(), 4'($urandom));
    add_cmd(OP_INSERT, $urandom, 4'($urandom));
    add_cmd(OP_LOOKUP, $urandom, 4'd15);
    add_cmd(OP_REMOVE, $urandom, 4'd15);
    add_cmd(OP_REMOVE, $urandom, 4'd0);

    // random: phases lean toward filling or draining the table
    fill_bias = 50;
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 60 == 0) fill_bias = $urandom_range(15, 85);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = OP_UNUSED;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < fill_bias) op = OP_INSERT;
        else if (roll < fill_bias + (100 - fill_bias) / 2) op = OP_LOOKUP;
        else op = OP_REMOVE;
      end
      if (gen_count > 0 && $urandom_range(0, 99) < 80)
        idx = 4'($urandom_range(0, gen_count - 1));
      else
        idx = 4'($urandom_range(0, 15));
      add_cmd(op, pick_value(), idx);
    end
  endtask

  // driver
  always @(posedge clk) begin
    sia_cmd_t c;
    int g;
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (!(start && busy)) begin
      g = 0;
      if (start) g = pick_gap();
      else if (gap_left > 0) g = gap_left;
      if (g == 0 && pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        in_op    <= c.op;
        in_value <= c.value;
        in_index <= c.index;
        start    <= 1'b1;
        gap_left <= 0;
      end else begin
        start    <= 1'b0;
        // junk on the bus while idle
        in_op    <= 2'($urandom);
        in_value <= $urandom;
        in_index <= 4'($urandom);
        gap_left <= (start || g == 0) ? ((g > 0) ? g - 1 : 0) : g - 1;
      end
    end
  end

  // monitor: predicts on each accepted transaction, then checks any result
  always @(posedge clk) begin
    sia_resp_t exp_r;
    if (rst_n) begin
      if (start && !busy)
        expected_resps.push_back(apply_cmd('{op: in_op, value: in_value, index: in_index}));
      if (out_valid) begin
        if (expected_resps.size() == 0) begin
          $error("unexpected result: no transaction outstanding");
          fail_cnt++;
        end else begin
          exp_r = expected_resps.pop_front();
          if (out_read_value !== exp_r.read_value) begin
            $error("read_value: expected %h, got %h", exp_r.read_value, out_read_value);
            fail_cnt++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            fail_cnt++;
          end
          if (out_entry_count !== exp_r.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.entry_count,
                   out_entry_count);
            fail_cnt++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_resps.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_resps.size() != 0) begin
      $error("%0d results never arrived", expected_resps.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/sia_pkg.sv
design/sia_ram.sv
design/sorted_insert_array.sv
tb/sv/tb_top.sv
